// ===== rtl/core/stick_diffusion_signal_defines.svh =====
// Assertion macros for the stick diffusion signal block.
// Needs a clock named clock and an active-high reset named reset in scope.
`ifndef STICK_DIFFUSION_SIGNAL_DEFINES_SVH
`define STICK_DIFFUSION_SIGNAL_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define SDS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SDS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sds_pkg.sv =====
// Shared types and constants for the stick diffusion signal block.
// No dependencies; imported by the top level.
`default_nettype none

package sds_pkg;

   // Field widths
   localparam int INDEX_W  = 6;
   localparam int COMP_W   = 16;
   localparam int SIG_W    = 16;
   localparam int B_W      = 15;
   localparam int DIFF_W   = 14;
   localparam int NUMG_W   = 7;
   localparam int CSR_W    = 15;
   localparam int CSR_IDX_W = 2;

   // Transaction modes
   localparam logic [1:0] MODE_WRITE  = 2'd0;
   localparam logic [1:0] MODE_SINGLE = 2'd1;
   localparam logic [1:0] MODE_SWEEP  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_B_VALUE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSIVITY = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_GRAD    = 2'd2;

   // Register reset values
   localparam logic [B_W-1:0]    B_VALUE_RST     = 15'd1000;
   localparam logic [DIFF_W-1:0] DIFFUSIVITY_RST = 14'd1000;
   localparam logic [NUMG_W-1:0] NUM_GRAD_RST    = 7'd0;

   // Entries a sweep may cover
   localparam int SWEEP_LIMIT = 64;

   // log2(e) * 1e-6 in Q0.48
   localparam logic [28:0] LOG2E_MICRO_Q48 = 29'd406082553;

   // Exponent at which the result underflows to zero
   localparam int UNDERFLOW_EXP = 17;

   // Q2.30 to Q0.16
   localparam int FRAC_SHIFT = 14;

   localparam logic [SIG_W-1:0] SIG_MAX = 16'hFFFF;

   // Result kind carried down the pipeline
   typedef logic [1:0] kind_type;
   localparam kind_type KIND_CALC = 2'd0;
   localparam kind_type KIND_ZERO = 2'd1;
   localparam kind_type KIND_FULL = 2'd2;

   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      logic               last;
      kind_type           kind;
   } tag_type;

   // 2^-(i/64) in Q2.30, entries 0 to 64
   localparam logic [63:0] ONE_Q30  = 64'd1073741824;
   localparam logic [63:0] STEP_Q30 = 64'd1062175491;
   localparam logic [63:0] HALF_Q30 = 64'd536870912;

   typedef logic [30:0] pow_tab_type [0:64];

   function automatic pow_tab_type build_pow_tab();
      pow_tab_type tab;
      logic [63:0] acc;
      int          i;
      acc = ONE_Q30;
      tab[0] = acc[30:0];
      for (i = 1; i < 64; i++) begin
         acc = (acc * STEP_Q30 + HALF_Q30) >> 30;
         tab[i] = acc[30:0];
      end
      acc = ONE_Q30 >> 1;
      tab[64] = acc[30:0];
      return tab;
   endfunction

   localparam pow_tab_type POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

// ===== rtl/core/sds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sds_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, hold data while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== rtl/core/stick_diffusion_signal.sv =====
// Stick-model diffusion attenuation engine: gradient table and signal pipeline.
// Depends on sds_pkg, sds_ram and stick_diffusion_signal_defines.svh.
//
// Channel  Dir  Handshake             Payload
// req      in   req_valid / req_stall mode, index, grad_x/y/z, fiber_x/y/z
// rsp      out  rsp_valid / rsp_stall signal, entry, last
// csr      in   csr_we                csr_index, csr_wdata
//
// A single-entry transaction gives its result once it has passed every pipeline stage.
// A sweep over N entries issues one entry per cycle from the sweep counter unless held,
// and holds req_stall until its last entry issues; a write gives no result.
// The 11-stage pipeline takes one gradient evaluation per cycle unless held.
// Reset is synchronous and clears control state; the gradient table is not cleared.
// rsp_stall freezes only the run of full stages ahead of the output; bubbles close up.
`default_nettype none
`include "stick_diffusion_signal_defines.svh"

module stick_diffusion_signal
   import sds_pkg::*;
#(
   parameter int MAX_GRADIENTS = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [1:0]               req_mode,
   input  wire logic [INDEX_W-1:0]       req_index,
   input  wire logic signed [COMP_W-1:0] req_grad_x,
   input  wire logic signed [COMP_W-1:0] req_grad_y,
   input  wire logic signed [COMP_W-1:0] req_grad_z,
   input  wire logic signed [COMP_W-1:0] req_fiber_x,
   input  wire logic signed [COMP_W-1:0] req_fiber_y,
   input  wire logic signed [COMP_W-1:0] req_fiber_z,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [SIG_W-1:0]              rsp_signal,
   output logic [INDEX_W-1:0]            rsp_entry,
   output logic                          rsp_last,
   // configuration
   input  wire logic                     csr_we,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [CSR_W-1:0]         csr_wdata
);

   localparam int NSTG  = 11;
   localparam int AW    = (MAX_GRADIENTS > 1) ? $clog2(MAX_GRADIENTS) : 1;
   localparam int EXT_W = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [8:0] MAX_G9 = 9'(MAX_GRADIENTS);
   localparam logic [NUMG_W-1:0] CNT_CAP =
      NUMG_W'((MAX_GRADIENTS < SWEEP_LIMIT) ? MAX_GRADIENTS : SWEEP_LIMIT);

   // ---------------------------------------------------------------- config
   logic [B_W-1:0]    b_value_ff;
   logic [DIFF_W-1:0] diffusivity_ff;
   logic [NUMG_W-1:0] num_grad_ff;
   logic [28:0]       bd_ff;
   logic [57:0]       kc_ff;
   logic [NUMG_W-1:0] cnt;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_value_ff     <= B_VALUE_RST;
         diffusivity_ff <= DIFFUSIVITY_RST;
         num_grad_ff    <= NUM_GRAD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_B_VALUE:     b_value_ff     <= csr_wdata;
            CSR_DIFFUSIVITY: diffusivity_ff <= csr_wdata[DIFF_W-1:0];
            CSR_NUM_GRAD:    num_grad_ff    <= csr_wdata[NUMG_W-1:0];
            default: ;
         endcase
      end
   end

   // Derive the exponent scale b*D*log2(e)*1e-6 over two stages
   always_ff @(posedge clock) begin
      bd_ff <= {14'd0, b_value_ff} * {15'd0, diffusivity_ff};
      kc_ff <= {29'd0, bd_ff} * {29'd0, LOG2E_MICRO_Q48};
   end

   // Entries in use
   assign cnt = (num_grad_ff > CNT_CAP) ? CNT_CAP : num_grad_ff;

   // ---------------------------------------------------------------- flow control
   logic [NSTG:1] v_ff;
   logic [NSTG:1] v_in;
   logic [NSTG:1] hold;
   int            hk;

   // A stage holds when it and every stage ahead of it are full and the output stalls
   always_comb begin
      for (hk = 1; hk <= NSTG; hk++) begin
         hold[hk] = rsp_stall &&
                    ((v_ff | NSTG'((1 << (hk - 1)) - 1)) == {NSTG{1'b1}});
      end
   end

   // ---------------------------------------------------------------- issue / sweep
   logic                     sweep_active_ff;
   logic [INDEX_W-1:0]       sweep_idx_ff;
   logic signed [COMP_W-1:0] sweep_fx_ff, sweep_fy_ff, sweep_fz_ff;
   logic                     req_acc;
   logic                     sweep_last;
   logic                     issue_v;
   logic [INDEX_W-1:0]       issue_idx;
   logic                     issue_last;
   logic                     issue_inr;
   logic signed [COMP_W-1:0] issue_fx, issue_fy, issue_fz;

   assign req_stall  = sweep_active_ff || hold[1];
   assign req_acc    = req_valid && !req_stall;
   assign sweep_last = ({1'b0, sweep_idx_ff} + 7'd1) == cnt;

   // Pick the evaluation to issue this cycle
   always_comb begin
      issue_v    = 1'b0;
      issue_idx  = req_index;
      issue_last = 1'b1;
      issue_inr  = 1'b1;
      issue_fx   = req_fiber_x;
      issue_fy   = req_fiber_y;
      issue_fz   = req_fiber_z;
      if (sweep_active_ff) begin
         issue_v    = 1'b1;
         issue_idx  = sweep_idx_ff;
         issue_last = sweep_last;
         issue_fx   = sweep_fx_ff;
         issue_fy   = sweep_fy_ff;
         issue_fz   = sweep_fz_ff;
      end else if (req_acc && req_mode == MODE_SINGLE) begin
         issue_v   = 1'b1;
         issue_inr = {1'b0, req_index} < cnt;
      end else if (req_acc && req_mode == MODE_SWEEP && cnt != '0) begin
         issue_v    = 1'b1;
         issue_idx  = '0;
         issue_last = (cnt == 7'd1);
      end
   end

   // Advance the sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_active_ff <= 1'b0;
         sweep_idx_ff    <= '0;
      end else if (!hold[1]) begin
         if (sweep_active_ff) begin
            if (sweep_last) begin
               sweep_active_ff <= 1'b0;
            end else begin
               sweep_idx_ff <= sweep_idx_ff + 6'd1;
            end
         end else if (req_acc && req_mode == MODE_SWEEP && cnt > 7'd1) begin
            sweep_active_ff <= 1'b1;
            sweep_idx_ff    <= 6'd1;
         end
      end
   end

   // Capture the fiber of a starting sweep
   always_ff @(posedge clock) begin
      if (req_acc && req_mode == MODE_SWEEP) begin
         sweep_fx_ff <= req_fiber_x;
         sweep_fy_ff <= req_fiber_y;
         sweep_fz_ff <= req_fiber_z;
      end
   end

   // ---------------------------------------------------------------- gradient table
   logic                   ram_we, ram_re;
   logic [EXT_W-1:0]       waddr_ext, raddr_ext;
   logic [3*COMP_W-1:0]    ram_rdata;

   assign ram_we    = req_acc && req_mode == MODE_WRITE && ({3'd0, req_index} < MAX_G9);
   assign ram_re    = issue_v && !hold[1];
   assign waddr_ext = EXT_W'(req_index);
   assign raddr_ext = EXT_W'(issue_idx);

   sds_ram #(
      .WIDTH  (3 * COMP_W),
      .DEPTH  (MAX_GRADIENTS),
      .ADDR_W (AW)
   ) u_grad_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr_ext[AW-1:0]),
      .wdata ({req_grad_x, req_grad_y, req_grad_z}),
      .re    (ram_re),
      .raddr (raddr_ext[AW-1:0]),
      .rdata (ram_rdata)
   );

   // ---------------------------------------------------------------- valid bits
   assign v_in = {v_ff[NSTG-1:1], issue_v};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= NSTG; k++) begin
            if (!hold[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // ---------------------------------------------------------------- tags
   tag_type s1_tag_ff;
   tag_type tag_ff [2:NSTG-1];
   tag_type tag_in [2:NSTG-1];
   logic    g_zero;
   logic    under;
   int      tk;

   // Tag of the issued evaluation
   always_ff @(posedge clock) begin
      if (!hold[1]) begin
         s1_tag_ff.idx  <= issue_idx;
         s1_tag_ff.last <= issue_last;
         s1_tag_ff.kind <= issue_inr ? KIND_CALC : KIND_ZERO;
      end
   end

   // Settle special cases as the tag moves on
   always_comb begin
      tag_in[2] = s1_tag_ff;
      if (s1_tag_ff.kind == KIND_CALC && g_zero) begin
         tag_in[2].kind = KIND_FULL;
      end
      for (tk = 3; tk <= NSTG - 1; tk++) begin
         tag_in[tk] = tag_ff[tk-1];
      end
      if (tag_ff[7].kind == KIND_CALC && under) begin
         tag_in[8].kind = KIND_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 2; k <= NSTG - 1; k++) begin
         if (!hold[k]) begin
            tag_ff[k] <= tag_in[k];
         end
      end
   end

   // ---------------------------------------------------------------- datapath
   logic signed [COMP_W-1:0] s1_fx_ff, s1_fy_ff, s1_fz_ff;
   logic signed [COMP_W-1:0] gx, gy, gz;
   logic signed [31:0]       s2_px_ff, s2_py_ff, s2_pz_ff;
   logic signed [33:0]       s3_dot_ff;
   logic [31:0]              s4_ad_ff;
   logic [63:0]              s5_dsq_ff;
   logic [60:0]              s6_pp00_ff, s6_pp01_ff, s6_pp10_ff, s6_pp11_ff;
   logic [33:0]              s7_low_hi_ff;
   logic [60:0]              s7_pp11_ff;
   logic [31:0]              s8_r_ff;
   logic [4:0]               s8_n_ff, s9_n_ff, s10_n_ff;
   logic [30:0]              s9_p0_ff;
   logic [23:0]              s9_prodhi_ff;
   logic [30:0]              s10_v_ff;
   logic [SIG_W-1:0]         rsp_signal_ff;
   logic [INDEX_W-1:0]       rsp_entry_ff;
   logic                     rsp_last_ff;

   logic signed [33:0]       dot;
   logic [94:0]              low;
   logic [61:0]              ysum;
   logic [22:0]              n_full;
   logic [5:0]               tab_i;
   logic [15:0]              tab_w;
   logic [30:0]              p0, p1, pdiff;
   logic [39:0]              prod;
   logic [30:0]              v;
   logic [4:0]               sh;
   logic [31:0]              rsum, rres;
   logic [SIG_W-1:0]         sig_calc;

   assign gx     = $signed(ram_rdata[3*COMP_W-1:2*COMP_W]);
   assign gy     = $signed(ram_rdata[2*COMP_W-1:COMP_W]);
   assign gz     = $signed(ram_rdata[COMP_W-1:0]);
   assign g_zero = (ram_rdata == '0);

   // Stage 1: fiber of the issued evaluation
   always_ff @(posedge clock) begin
      if (!hold[1]) begin
         s1_fx_ff <= issue_fx;
         s1_fy_ff <= issue_fy;
         s1_fz_ff <= issue_fz;
      end
   end

   // Stage 2: component products
   always_ff @(posedge clock) begin
      if (!hold[2]) begin
         s2_px_ff <= s1_fx_ff * gx;
         s2_py_ff <= s1_fy_ff * gy;
         s2_pz_ff <= s1_fz_ff * gz;
      end
   end

   // Stage 3: dot product
   assign dot = 34'(s2_px_ff) + 34'(s2_py_ff) + 34'(s2_pz_ff);

   always_ff @(posedge clock) begin
      if (!hold[3]) begin
         s3_dot_ff <= dot;
      end
   end

   // Stage 4: magnitude
   always_ff @(posedge clock) begin
      if (!hold[4]) begin
         s4_ad_ff <= s3_dot_ff[33] ? 32'(-s3_dot_ff) : 32'(s3_dot_ff);
      end
   end

   // Stage 5: square
   always_ff @(posedge clock) begin
      if (!hold[5]) begin
         s5_dsq_ff <= {32'd0, s4_ad_ff} * {32'd0, s4_ad_ff};
      end
   end

   // Stage 6: partial products of scale times square
   always_ff @(posedge clock) begin
      if (!hold[6]) begin
         s6_pp00_ff <= {32'd0, kc_ff[28:0]}  * {29'd0, s5_dsq_ff[31:0]};
         s6_pp01_ff <= {32'd0, kc_ff[28:0]}  * {29'd0, s5_dsq_ff[63:32]};
         s6_pp10_ff <= {32'd0, kc_ff[57:29]} * {29'd0, s5_dsq_ff[31:0]};
         s6_pp11_ff <= {32'd0, kc_ff[57:29]} * {29'd0, s5_dsq_ff[63:32]};
      end
   end

   // Stage 7: sum the lower partial products, keep the bits that reach the top
   assign low = {34'd0, s6_pp00_ff}
              + ({34'd0, s6_pp10_ff} << 29)
              + ({34'd0, s6_pp01_ff} << 32);

   always_ff @(posedge clock) begin
      if (!hold[7]) begin
         s7_low_hi_ff <= low[94:61];
         s7_pp11_ff   <= s6_pp11_ff;
      end
   end

   // Stage 8: exponent in Q.32, split into integer and fraction
   assign ysum   = {1'b0, s7_pp11_ff} + {28'd0, s7_low_hi_ff};
   assign n_full = ysum[61:39];
   assign under  = n_full >= 23'(UNDERFLOW_EXP);

   always_ff @(posedge clock) begin
      if (!hold[8]) begin
         s8_r_ff <= ysum[38:7];
         s8_n_ff <= n_full[4:0];
      end
   end

   // Stage 9: table look-up and interpolation product
   assign tab_i = s8_r_ff[31:26];
   assign tab_w = s8_r_ff[25:10];
   assign p0    = POW_TAB[{1'b0, tab_i}];
   assign p1    = POW_TAB[{1'b0, tab_i} + 7'd1];
   assign pdiff = p0 - p1;
   assign prod  = {16'd0, pdiff[23:0]} * {24'd0, tab_w};

   always_ff @(posedge clock) begin
      if (!hold[9]) begin
         s9_p0_ff     <= p0;
         s9_prodhi_ff <= prod[39:16];
         s9_n_ff      <= s8_n_ff;
      end
   end

   // Stage 10: interpolated fraction power
   assign v = s9_p0_ff - {7'd0, s9_prodhi_ff};

   always_ff @(posedge clock) begin
      if (!hold[10]) begin
         s10_v_ff <= v;
         s10_n_ff <= s9_n_ff;
      end
   end

   // Output stage: shift by the integer part, round half up, saturate
   assign sh       = 5'(FRAC_SHIFT) + s10_n_ff;
   assign rsum     = {1'b0, s10_v_ff} + (32'd1 << (sh - 5'd1));
   assign rres     = rsum >> sh;
   assign sig_calc = (rres[31:SIG_W] != '0) ? SIG_MAX : rres[SIG_W-1:0];

   always_ff @(posedge clock) begin
      if (!hold[NSTG]) begin
         rsp_entry_ff <= tag_ff[NSTG-1].idx;
         rsp_last_ff  <= tag_ff[NSTG-1].last;
         case (tag_ff[NSTG-1].kind)
            KIND_CALC: rsp_signal_ff <= sig_calc;
            KIND_FULL: rsp_signal_ff <= SIG_MAX;
            default:   rsp_signal_ff <= '0;
         endcase
      end
   end

   assign rsp_valid  = v_ff[NSTG];
   assign rsp_signal = rsp_signal_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_last   = rsp_last_ff;

   // ---------------------------------------------------------------- assertions
   `SDS_ASSERT_NEXT(a_ram_held, v_ff[1] && hold[1], $stable(ram_rdata), "table data moved under a held stage")
   `SDS_ASSERT_NOW(a_no_rw_clash, ram_we, !ram_re, "table write and read issued together")
   `SDS_ASSERT_NEXT(a_sweep_end, sweep_active_ff && !hold[1] && sweep_last, !sweep_active_ff, "sweep ran past its last entry")
   `SDS_ASSERT_NEXT(a_sweep_start, req_acc && req_mode == MODE_SWEEP && cnt > 7'd1, sweep_active_ff && sweep_idx_ff == 6'd1, "sweep did not start")

endmodule

`default_nettype wire
